@@ src/binary_bayes_filter_core_assert.svh @@
// ----------------------------------------------------------------------------
// binary bayes filter assertion macros
// shared property forms for the filter's concurrent checks
// ----------------------------------------------------------------------------
`ifndef BINARY_BAYES_FILTER_CORE_ASSERT_SVH
`define BINARY_BAYES_FILTER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BBF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbf check failed");

// next-cycle implication, disabled during reset
`define BBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbf check failed");

`endif

@@ src/bbf_pkg.sv @@
// ----------------------------------------------------------------------------
// bbf_pkg
// shared types and constants of the two-state bayes filter
// ----------------------------------------------------------------------------
package bbf_pkg;

  // q1.15 probability width and the value standing for one
  localparam int unsigned QW = 16;
  localparam logic [QW-1:0] Q_ONE = 16'h8000;
  localparam logic [QW-1:0] Q_HALF = 16'h4000;

  // serial divider runs one quotient bit per cycle
  localparam int unsigned DIV_STEPS = QW;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SENS_OO = 3'd0,
    REG_SENS_OC = 3'd1,
    REG_PUSH_OO = 3'd2,
    REG_PUSH_OC = 3'd3,
    REG_IDLE_OO = 3'd4,
    REG_IDLE_OC = 3'd5
  } reg_index_t;

  // multiplier operations, issued in this order
  typedef enum logic [2:0] {
    OP_PO_A = 3'd0,  // p * open belief
    OP_PO_B = 3'd1,  // q * closed belief
    OP_PC_A = 3'd2,  // (1-p) * open belief
    OP_PC_B = 3'd3,  // (1-q) * closed belief
    OP_WO   = 3'd4,  // sensor open weight * predicted open
    OP_WC   = 3'd5   // sensor closed weight * predicted closed
  } mul_op_t;

  localparam int unsigned MUL_OPS = 6;

  typedef struct packed {
    logic [QW-1:0] sens_oo;
    logic [QW-1:0] sens_oc;
    logic [QW-1:0] push_oo;
    logic [QW-1:0] push_oc;
    logic [QW-1:0] idle_oo;
    logic [QW-1:0] idle_oc;
  } cfg_regs_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    mul_go;
    mul_op_t mul_op;
    logic    norm_load;
    logic    div_init;
    logic    div_sel;     // 0 open weight, 1 closed weight
    logic    div_step;
    logic    div_store;
    logic    commit;
  } bbf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic norm_zero;
  } bbf_stat_t;

  typedef struct packed {
    logic [QW-1:0] predicted_open;
    logic [QW-1:0] predicted_closed;
    logic [QW-1:0] belief_open;
    logic [QW-1:0] belief_closed;
    logic          degenerate;
  } bbf_result_t;

endpackage

@@ src/bbf_ctrl.sv @@
// ----------------------------------------------------------------------------
// bbf_ctrl
// sequencer for the filter: multiply phase, normalise, two serial divides
// ----------------------------------------------------------------------------
module bbf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               out_free,
  input  bbf_pkg::bbf_stat_t stat,
  output bbf_pkg::bbf_cmd_t  cmd
);
  import bbf_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_DRAIN  = 9'b000000100,
    S_NORM   = 9'b000001000,
    S_INIT_O = 9'b000010000,
    S_DIV_O  = 9'b000100000,
    S_INIT_C = 9'b001000000,
    S_DIV_C  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_OPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_op = mul_op_t'(cnt[2:0]);
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end
      end
      // last product still being written back
      S_DRAIN: state_next = S_NORM;
      S_NORM: begin
        cmd.norm_load = 1'b1;
        state_next    = S_INIT_O;
      end
      S_INIT_O: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = stat.norm_zero ? S_DONE : S_DIV_O;
      end
      S_DIV_O: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_LAST) state_next = S_INIT_C;
      end
      S_INIT_C: begin
        cmd.div_store = 1'b1;
        cmd.div_init  = 1'b1;
        cmd.div_sel   = 1'b1;
        cnt_next      = '0;
        state_next    = S_DIV_C;
      end
      S_DIV_C: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_LAST) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);

endmodule

@@ src/bbf_dpath.sv @@
// ----------------------------------------------------------------------------
// bbf_dpath
// belief state, shared 16x16 multiplier and restoring divider
// ----------------------------------------------------------------------------
module bbf_dpath (
  input  logic                 clk,
  input  logic                 rst,
  input  bbf_pkg::cfg_regs_t   cfg,
  input  logic                 in_pushing,
  input  logic                 in_measured_open,
  input  bbf_pkg::bbf_cmd_t    cmd,
  output bbf_pkg::bbf_stat_t   stat,
  output bbf_pkg::bbf_result_t res
);
  import bbf_pkg::*;

  // saturate a sum of two q1.15 terms to one
  function automatic logic [QW-1:0] sat_one(input logic [QW:0] v);
    logic [QW-1:0] r;
    r = (v > {1'b0, Q_ONE}) ? Q_ONE : v[QW-1:0];
    return r;
  endfunction

  logic            pushing, measured_open;
  logic [QW-1:0]   bel_o, bel_c;
  logic [QW-1:0]   op_a, op_b;
  logic [2*QW-1:0] prod;
  mul_op_t         prod_op;
  logic            prod_vld;
  logic [QW-1:0]   prod_sh;
  logic [QW-1:0]   acc, pred_o, pred_c, wo, wc;
  logic [QW:0]     norm;
  logic [QW:0]     rem;
  logic            dbit;
  logic [QW-1:0]   quo, new_o;
  logic [QW-1:0]   p, q, so, sc, w_sel;
  logic [QW+1:0]   trial, trial_sub;
  logic            ge;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pushing       <= in_pushing;
      measured_open <= in_measured_open;
    end
  end

  // transition column and sensor likelihood selection
  always_comb begin
    p  = pushing ? cfg.push_oo : cfg.idle_oo;
    q  = pushing ? cfg.push_oc : cfg.idle_oc;
    so = measured_open ? cfg.sens_oo : Q_ONE - cfg.sens_oo;
    sc = measured_open ? cfg.sens_oc : Q_ONE - cfg.sens_oc;
  end

  // multiplier operand mux
  always_comb begin
    case (cmd.mul_op)
      OP_PO_A: begin op_a = p;         op_b = bel_o;  end
      OP_PO_B: begin op_a = q;         op_b = bel_c;  end
      OP_PC_A: begin op_a = Q_ONE - p; op_b = bel_o;  end
      OP_PC_B: begin op_a = Q_ONE - q; op_b = bel_c;  end
      OP_WO:   begin op_a = so;        op_b = pred_o; end
      OP_WC:   begin op_a = sc;        op_b = pred_c; end
      default: begin op_a = '0;        op_b = '0;     end
    endcase
  end

  // registered product with its operation tag
  always_ff @(posedge clk) begin
    prod    <= op_a * op_b;
    prod_op <= cmd.mul_op;
    if (rst) prod_vld <= 1'b0;
    else     prod_vld <= cmd.mul_go;
  end

  assign prod_sh = prod[2*QW-2:QW-1];

  // product write-back
  always_ff @(posedge clk) begin
    if (prod_vld) begin
      case (prod_op)
        OP_PO_A: acc    <= prod_sh;
        OP_PO_B: pred_o <= sat_one({1'b0, acc} + {1'b0, prod_sh});
        OP_PC_A: acc    <= prod_sh;
        OP_PC_B: pred_c <= sat_one({1'b0, acc} + {1'b0, prod_sh});
        OP_WO:   wo     <= prod_sh;
        OP_WC:   wc     <= prod_sh;
        default: acc    <= acc;
      endcase
    end
  end

  // restoring divide of w*2^15 by norm, one quotient bit per cycle
  assign w_sel     = cmd.div_sel ? wc : wo;
  assign trial     = {rem, dbit};
  assign ge        = (trial >= {1'b0, norm});
  assign trial_sub = trial - {1'b0, norm};

  always_ff @(posedge clk) begin
    if (cmd.norm_load) norm <= {1'b0, wo} + {1'b0, wc};
    if (cmd.div_store) new_o <= quo;
    if (cmd.div_init) begin
      rem  <= {2'b00, w_sel[QW-1:1]};
      dbit <= w_sel[0];
      quo  <= '0;
    end else if (cmd.div_step) begin
      rem  <= ge ? trial_sub[QW:0] : trial[QW:0];
      dbit <= 1'b0;
      quo  <= {quo[QW-2:0], ge};
    end
  end

  assign stat.norm_zero = (norm == '0);

  // belief state, kept when the normaliser is zero
  always_ff @(posedge clk) begin
    if (rst) begin
      bel_o <= Q_HALF;
      bel_c <= Q_HALF;
    end else if (cmd.commit && !stat.norm_zero) begin
      bel_o <= new_o;
      bel_c <= quo;
    end
  end

  // result word
  always_comb begin
    res.predicted_open   = pred_o;
    res.predicted_closed = pred_c;
    res.belief_open      = stat.norm_zero ? bel_o : new_o;
    res.belief_closed    = stat.norm_zero ? bel_c : quo;
    res.degenerate       = stat.norm_zero;
  end

endmodule

@@ src/binary_bayes_filter_core.sv @@
// ----------------------------------------------------------------------------
// binary_bayes_filter_core
// two-state (open / closed) discrete bayes filter with q1.15 arithmetic
// ----------------------------------------------------------------------------
// Each input word carries a control bit and a binary measurement; one result
// word follows with the predicted and corrected beliefs and a degenerate flag.
// An item occupies the core from the cycle in which it is accepted until its
// result is registered: six operations through a single registered 16x16
// multiplier, then two 16-step restoring divides that share one subtractor,
// both divides skipped when the normaliser is zero.
// A new word is accepted once the result is registered, even if it has not
// yet been taken downstream. Configuration writes take effect at once and are
// meant for idle periods; values above one saturate to one.
`include "binary_bayes_filter_core_assert.svh"

module binary_bayes_filter_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] pushing, [1] measured_open, rest zero
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [15:0] predicted_open, [31:16] predicted_closed,
                                 // [47:32] belief_open, [63:48] belief_closed
  output logic        m_tuser,   // [0] degenerate
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bbf_pkg::*;

  cfg_regs_t   cfg;
  bbf_cmd_t    cmd;
  bbf_stat_t   stat;
  bbf_result_t res;
  logic        out_free;
  logic [15:0] cfg_sat;
  logic [16:0] out_sum;
  logic        cfg_ok;

  // configuration registers, clamped to one on write
  assign cfg_ready = 1'b1;
  assign cfg_sat   = (cfg_data > Q_ONE) ? Q_ONE : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sens_oo <= 16'd19661;
      cfg.sens_oc <= 16'd6554;
      cfg.push_oo <= Q_ONE;
      cfg.push_oc <= 16'd26214;
      cfg.idle_oo <= Q_ONE;
      cfg.idle_oc <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SENS_OO: cfg.sens_oo <= cfg_sat;
        REG_SENS_OC: cfg.sens_oc <= cfg_sat;
        REG_PUSH_OO: cfg.push_oo <= cfg_sat;
        REG_PUSH_OC: cfg.push_oc <= cfg_sat;
        REG_IDLE_OO: cfg.idle_oo <= cfg_sat;
        REG_IDLE_OC: cfg.idle_oc <= cfg_sat;
        default: ;
      endcase
    end
  end

  bbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  bbf_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_pushing       (s_tdata[0]),
    .in_measured_open (s_tdata[1]),
    .cmd              (cmd),
    .stat             (stat),
    .res              (res)
  );

  // result register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {res.belief_closed, res.belief_open,
                  res.predicted_closed, res.predicted_open};
      m_tuser <= res.degenerate;
    end
  end

  // checks
  assign out_sum = {1'b0, m_tdata[47:32]} + {1'b0, m_tdata[63:48]};
  assign cfg_ok  = (cfg.sens_oo <= Q_ONE) && (cfg.sens_oc <= Q_ONE) &&
                   (cfg.push_oo <= Q_ONE) && (cfg.push_oc <= Q_ONE) &&
                   (cfg.idle_oo <= Q_ONE) && (cfg.idle_oc <= Q_ONE);

  `BBF_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `BBF_ASSERT_NOW(a_commit_when_free, clk, rst, cmd.commit, out_free)
  `BBF_ASSERT_NOW(a_beliefs_sum_le_one, clk, rst, m_tvalid && !m_tuser, out_sum <= 17'd32768)
  `BBF_ASSERT_NOW(a_cfg_at_most_one, clk, rst, 1'b1, cfg_ok)

endmodule
